### rtl/core/lindhard_response_sum_defines.svh
// assertion macros for the lindhard response sum checker
// no dependencies
`ifndef LINDHARD_RESPONSE_SUM_DEFINES_SVH
`define LINDHARD_RESPONSE_SUM_DEFINES_SVH
`define LRS_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define LRS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### rtl/core/lrs_pkg.sv
// types, constants and the cosine polynomial for the lindhard response sum
// no dependencies
package lrs_pkg;
   localparam int ANGLE_BITS = 16;
   localparam int ENERGY_FRAC_BITS = 12;
   localparam int NUM_BITS = 32 + ENERGY_FRAC_BITS;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] REG_Q_X = 3'd0;
   localparam logic [2:0] REG_Q_Y = 3'd1;
   localparam logic [2:0] REG_HOP = 3'd2;
   localparam logic [2:0] REG_MU = 3'd3;
   localparam logic [2:0] REG_GAP = 3'd4;
   localparam logic [2:0] REG_WEIGHT = 3'd5;

   localparam logic [28:0] ONE_Q28 = 29'd268435456;
   localparam logic [28:0] COS_C1 = 29'd331168970;
   localparam logic [28:0] COS_C2 = 29'd68093890;
   localparam logic [28:0] COS_C3 = 29'd5600498;
   localparam logic [28:0] COS_C4 = 29'd246762;
   localparam logic [28:0] COS_C5 = 29'd6765;

   typedef struct packed {
      logic [15:0] k_angle_x;
      logic [15:0] k_angle_y;
      logic last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] response_sum;
      logic saturated;
   } rsp_type;

   // one classified work item for the back end
   typedef struct packed {
      logic add;
      logic neg;
      logic [17:0] mag_gap;
      logic last;
   } job_type;
endpackage

### rtl/core/lrs_front.sv
// front end: band energies via a shared cosine polynomial unit, occupation test
// depends on lrs_pkg
module lrs_front
   import lrs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   input  logic [15:0] q_x,
   input  logic [15:0] q_y,
   input  logic [14:0] hop,
   input  logic signed [15:0] mu,
   input  logic [11:0] min_gap,
   output logic job_valid,
   input  logic job_ready,
   output job_type job_data
);
   typedef enum logic [2:0] {S_IDLE, S_SETUP, S_POLY, S_ENERGY, S_SEND} state_type;

   state_type state_ff;
   logic [1:0] idx_ff;
   logic [2:0] step_ff;
   logic [15:0] ang_ff [4];
   logic last_ff;
   logic [28:0] w_ff, p_ff;
   logic c_neg_ff;
   logic signed [30:0] csum_ff;
   logic signed [17:0] ek_ff;
   logic signed [17:0] en_ff;

   logic [ANGLE_BITS-1:0] m;
   logic [ANGLE_BITS-3:0] r;
   logic [ANGLE_BITS-2:0] y;
   logic [29:0] z;
   logic [59:0] zz;
   logic [57:0] wp;
   logic [28:0] p_next;
   logic signed [29:0] cval;
   logic signed [47:0] prod;
   logic signed [47:0] rnd;
   logic signed [17:0] e_new;
   logic fk, fkq;
   logic signed [18:0] gap;
   logic [18:0] mg;
   logic [1:0] quad;

   always_comb begin
      m = ang_ff[idx_ff][ANGLE_BITS-1:0];
      quad = m[ANGLE_BITS-1:ANGLE_BITS-2];
      r = m[ANGLE_BITS-3:0];
      y = quad[0] ? ({1'b1, {(ANGLE_BITS-2){1'b0}}} - {1'b0, r}) : {1'b0, r};
      z = 30'(y) << (30 - ANGLE_BITS);
      zz = z * z;
      wp = w_ff * p_ff;
      p_next = COS_C1;
      case (step_ff)
         3'd0: p_next = COS_C4 - 29'(wp >> 28);
         3'd1: p_next = COS_C3 - 29'(wp >> 28);
         3'd2: p_next = COS_C2 - 29'(wp >> 28);
         3'd3: p_next = COS_C1 - 29'(wp >> 28);
         default: p_next = COS_C1;
      endcase
      cval = 30'(ONE_Q28) - 30'(wp >> 28);
      if (cval < 0) cval = '0;
      prod = -48'sd2 * $signed({1'b0, hop}) * 48'(csum_ff);
      rnd = prod + 48'sd134217728;
      e_new = 18'(rnd >>> 28);
      fk = ek_ff < mu;
      fkq = en_ff < mu;
      gap = 19'(ek_ff) - 19'(en_ff);
      mg = gap[18] ? 19'(-gap) : gap;
      job_data.add = fk != fkq && mg > 19'(min_gap);
      job_data.neg = (fk != fkq) && ((fk == 1'b1) != gap[18]);
      job_data.mag_gap = 18'(mg);
      job_data.last = last_ff;
   end

   assign req_ready = state_ff == S_IDLE;
   assign job_valid = state_ff == S_SEND;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ang_ff[0] <= req_data.k_angle_x;
                  ang_ff[1] <= req_data.k_angle_y;
                  ang_ff[2] <= req_data.k_angle_x + q_x;
                  ang_ff[3] <= req_data.k_angle_y + q_y;
                  last_ff <= req_data.last_point;
                  idx_ff <= '0;
                  csum_ff <= '0;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               w_ff <= 29'(zz >> 28);
               p_ff <= COS_C5;
               c_neg_ff <= quad == 2'd1 || quad == 2'd2;
               step_ff <= '0;
               state_ff <= S_POLY;
            end
            S_POLY: begin
               if (step_ff == 3'd4) begin
                  csum_ff <= c_neg_ff ? csum_ff - 31'(cval) : csum_ff + 31'(cval);
                  if (idx_ff[0]) state_ff <= S_ENERGY;
                  else state_ff <= S_SETUP;
                  idx_ff <= idx_ff + 2'd1;
               end else begin
                  p_ff <= p_next;
                  step_ff <= step_ff + 3'd1;
               end
            end
            S_ENERGY: begin
               csum_ff <= '0;
               if (idx_ff == 2'd2) begin
                  ek_ff <= e_new;
                  state_ff <= S_SETUP;
               end else begin
                  en_ff <= e_new;
                  state_ff <= S_SEND;
               end
            end
            S_SEND: begin
               if (job_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### rtl/core/lrs_queue.sv
// two entry queue between front and back
// depends on lrs_pkg
module lrs_queue
   import lrs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  job_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output job_type out_data
);
   job_type mem_ff [QUEUE_DEPTH];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

### rtl/core/lrs_back.sv
// back end: serial divider, saturating accumulator and result register
// depends on lrs_pkg
module lrs_back
   import lrs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  job_type job_data,
   input  logic [31:0] weight,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [1:0] {B_IDLE, B_DIV, B_ACC, B_OUT} state_type;

   state_type state_ff;
   job_type job_ff;
   logic [5:0] cnt_ff;
   logic [NUM_BITS-1:0] quo_ff;
   logic [33:0] rem_ff;
   logic signed [47:0] acc_ff;
   logic clip_ff;
   rsp_type rsp_ff;

   logic [33:0] den;
   logic [35:0] trial;
   logic [34:0] rem_sh;
   logic [NUM_BITS:0] term;
   logic signed [49:0] nxt;
   logic [33:0] half;
   logic [33:0] rem_r;

   always_comb begin
      den = 34'(job_ff.mag_gap) << 16;
      rem_sh = {rem_ff, quo_ff[NUM_BITS-1]};
      trial = {1'b0, rem_sh} - {2'b0, den};
      // round to nearest: compare remainder with den/2
      half = den >> 1;
      rem_r = rem_ff;
      term = {1'b0, quo_ff} + ((rem_r >= den - half) ? 45'd1 : 45'd0);
      nxt = job_ff.neg ? 50'(acc_ff) - 50'(term) : 50'(acc_ff) + 50'(term);
   end

   assign job_ready = state_ff == B_IDLE;
   assign rsp_valid = state_ff == B_OUT;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         acc_ff <= '0;
         clip_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  quo_ff <= {weight, {ENERGY_FRAC_BITS{1'b0}}};
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= job_data.add ? B_DIV : B_ACC;
               end
            end
            B_DIV: begin
               if (!trial[35]) begin
                  rem_ff <= trial[33:0];
                  quo_ff <= {quo_ff[NUM_BITS-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[33:0];
                  quo_ff <= {quo_ff[NUM_BITS-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(NUM_BITS - 1)) state_ff <= B_ACC;
            end
            B_ACC: begin
               logic signed [47:0] a;
               logic c;
               a = acc_ff;
               c = clip_ff;
               if (job_ff.add) begin
                  if (nxt > 50'sh7FFFFFFFFFFF) begin
                     a = 48'sh7FFFFFFFFFFF;
                     c = 1'b1;
                  end else if (nxt < -50'sh800000000000) begin
                     a = 48'sh800000000000;
                     c = 1'b1;
                  end else begin
                     a = 48'(nxt);
                  end
               end
               if (job_ff.last) begin
                  if (a > 48'sh00007FFFFFFF) begin
                     rsp_ff.response_sum <= 32'sh7FFFFFFF;
                     rsp_ff.saturated <= 1'b1;
                  end else if (a < -48'sh000080000000) begin
                     rsp_ff.response_sum <= 32'sh80000000;
                     rsp_ff.saturated <= 1'b1;
                  end else begin
                     rsp_ff.response_sum <= 32'(a);
                     rsp_ff.saturated <= c;
                  end
                  acc_ff <= '0;
                  clip_ff <= 1'b0;
                  state_ff <= B_OUT;
               end else begin
                  acc_ff <= a;
                  clip_ff <= c;
                  state_ff <= B_IDLE;
               end
            end
            B_OUT: begin
               if (rsp_ready) state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule

### rtl/core/lindhard_response_sum.sv
// Lindhard response sum for a 2D tight-binding band, one grid point per req beat.
// A point passes the front end (four cosine polynomials on one shared multiplier
// plus two energy steps) and the back end, whose bit-serial divider over 44 quotient
// bits, run only for points that add a term, then sets the sustained rate; a two-entry
// queue lets the front work on the next point while the back divides.
// depends on lrs_pkg, lrs_front, lrs_queue, lrs_back
module lindhard_response_sum
   import lrs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   logic [15:0] q_x_ff, q_y_ff;
   logic [14:0] hop_ff;
   logic signed [15:0] mu_ff;
   logic [11:0] gap_ff;
   logic [31:0] weight_ff;
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj_data, bj_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_x_ff <= '0;
         q_y_ff <= '0;
         hop_ff <= 15'd4096;
         mu_ff <= -16'sd4096;
         gap_ff <= 12'd1;
         weight_ff <= 32'd4295;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_Q_X: q_x_ff <= csr_data[15:0];
            REG_Q_Y: q_y_ff <= csr_data[15:0];
            REG_HOP: hop_ff <= csr_data[14:0];
            REG_MU: mu_ff <= csr_data[15:0];
            REG_GAP: gap_ff <= csr_data[11:0];
            REG_WEIGHT: weight_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lrs_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_x(q_x_ff), .q_y(q_y_ff), .hop(hop_ff), .mu(mu_ff), .min_gap(gap_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   lrs_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   lrs_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .weight(weight_ff), .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

### rtl/core/lrs_checker.sv
// port-level checker for lindhard_response_sum, bound to the top level
// depends on lrs_pkg and lindhard_response_sum_defines.svh
`include "lindhard_response_sum_defines.svh"
module lrs_checker
   import lrs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);
   `LRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `LRS_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)
   `LRS_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
   `LRS_ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid)
endmodule

bind lindhard_response_sum lrs_checker u_lrs_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
